### hdl/gub_pkg.sv
`timescale 1ns / 1ps
package gub_pkg;

    localparam int unsigned CFG_W = 32;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned IDLE_W = 17;

    localparam logic [CFG_IDX_W-1:0] REG_PART_SIZE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_QUEUES = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_IDLE_LIMIT = 2'd2;

    localparam logic [31:0] PART_SIZE_RST = 32'd127;
    localparam logic [5:0] QUEUES_RST = 6'd2;
    localparam logic [15:0] IDLE_LIMIT_RST = 16'd15000;

    localparam logic [1:0] KIND_BATCH = 2'd0;
    localparam logic [1:0] KIND_DONE = 2'd1;
    localparam logic [1:0] KIND_DROP = 2'd2;

    typedef struct packed {
        logic        req_type;
        logic [31:0] source_dist;
        logic [31:0] edge_weight;
        logic [31:0] dest_vertex;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  result_kind;
        logic [4:0]  queue_index;
        logic [31:0] out_vertex;
        logic [31:0] new_dist;
        logic [2:0]  slot;
        logic        last_in_batch;
        logic        done_value;
    } t_out_item;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_FILL_RD,
        ST_WRITE,
        ST_EMIT
    } t_state;

endpackage

### hdl/graph_update_batcher_top.sv
`timescale 1ns / 1ps
// Channel  | Direction | Handshake                  | Payload
// input    | in        | i_start high, o_busy low   | i_in   (t_in_item)
// result   | out       | o_valid strobe, one cycle  | o_out  (t_out_item)
// config   | in        | i_cfg_we                   | i_cfg_idx, i_cfg_data
//
// Idle poll: taken in ST_IDLE without leaving it; a done change is strobed the cycle after.
// Edge: the bit-serial divider (32 steps plus its done strobe), then ST_FILL_RD
// for the fill index read and ST_WRITE for the store write; a dropped update
// skips ST_WRITE, and when the last slot fills, ST_EMIT streams eight store reads
// out one result per cycle. Clearing done strobes its status during the divide.
// Reset is synchronous, active low; it clears the fill indexes, idle count and
// done flag. The batch store has no reset. The receiver cannot stall.
module graph_update_batcher_top import gub_pkg::*; #(
    parameter int NUM_QUEUES = 32,
    parameter int BATCH_LEN  = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  t_in_item             i_in,
    output logic                 o_busy,
    output logic                 o_valid,
    output t_out_item            o_out,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data
);
    localparam int QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
    localparam int SW = $clog2(BATCH_LEN);
    localparam int AW = QW + SW;
    localparam int DEPTH = 1 << AW;
    localparam logic [IDLE_W-1:0] IDLE_MAX = {IDLE_W{1'b1}};

    // configuration registers
    logic [31:0] r_part_size;
    logic [5:0]  r_queues;
    logic [15:0] r_idle_limit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_part_size  <= PART_SIZE_RST;
            r_queues     <= QUEUES_RST;
            r_idle_limit <= IDLE_LIMIT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_PART_SIZE:  r_part_size  <= i_cfg_data;
                REG_QUEUES:     r_queues     <= i_cfg_data[5:0];
                REG_IDLE_LIMIT: r_idle_limit <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // control
    t_state r_state, n_state;
    logic [QW-1:0]     r_q;
    logic [31:0]       r_vtx, r_dist;
    logic [SW-1:0]     r_slot;
    logic [IDLE_W-1:0] r_idle;
    logic              r_done_bit;
    logic              r_pend_edge;
    logic              r_out_vld;
    t_out_item         r_out;

    // memories: batch store and fill index, both with a registered read
    logic [63:0]   m_store [DEPTH];
    logic [SW-1:0] m_fill  [NUM_QUEUES];
    logic [NUM_QUEUES-1:0] r_fill_vld;
    logic          st_we;
    logic [AW-1:0] st_waddr, st_raddr;
    logic [63:0]   st_wdata, r_st_rdata;
    logic          fi_we;
    logic [SW-1:0] fi_wdata, r_fi_rdata;
    logic          r_fi_vld;

    always_ff @(posedge i_clk) begin
        if (st_we) m_store[st_waddr] <= st_wdata;
        r_st_rdata <= m_store[st_raddr];
        if (fi_we) m_fill[r_q] <= fi_wdata;
        r_fi_rdata <= m_fill[r_q];
    end

    // fill index entries read as zero until first written after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill_vld <= '0;
            r_fi_vld   <= 1'b0;
        end else begin
            r_fi_vld <= r_fill_vld[r_q];
            if (fi_we) r_fill_vld[r_q] <= 1'b1;
        end
    end

    logic        div_start, div_done;
    logic [31:0] div_quot;
    logic [6:0]  w_limit;
    logic [SW-1:0] w_fill;
    logic [IDLE_W-1:0] w_idle_inc;

    gub_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (i_in.dest_vertex),
        .i_divisor  (r_part_size),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    assign o_busy = (r_state != ST_IDLE);
    assign w_limit = ({1'b0, r_queues} > 7'(NUM_QUEUES)) ? 7'(NUM_QUEUES)
                                                           : {1'b0, r_queues};
    assign w_fill = r_fi_vld ? r_fi_rdata : '0;
    assign w_idle_inc = (r_idle == IDLE_MAX) ? r_idle : r_idle + 1'b1;

    always_comb begin
        n_state   = r_state;
        div_start = 1'b0;
        st_we     = 1'b0;
        st_waddr  = {r_q, w_fill};
        st_wdata  = {r_vtx, r_dist};
        st_raddr  = {r_q, r_slot};
        fi_we     = 1'b0;
        fi_wdata  = w_fill + 1'b1;
        case (r_state)
            ST_IDLE: begin
                if (i_start && i_in.req_type) begin
                    div_start = 1'b1;
                    n_state   = ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_done) n_state = ST_FILL_RD;
            end
            ST_FILL_RD: begin
                // fill index read launched at r_q this cycle
                if (r_pend_edge) n_state = ST_IDLE;
                else n_state = ST_WRITE;
            end
            ST_WRITE: begin
                st_we = 1'b1;
                fi_we = 1'b1;
                if (w_fill == SW'(BATCH_LEN - 1)) begin
                    fi_wdata = '0;
                    st_raddr = {r_q, {SW{1'b0}}};
                    n_state  = ST_EMIT;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_EMIT: begin
                st_raddr = {r_q, r_slot + 1'b1};
                if (r_slot == SW'(BATCH_LEN - 1)) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= ST_IDLE;
        else          r_state <= n_state;
    end

    // datapath and results
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idle      <= '0;
            r_done_bit  <= 1'b0;
            r_out_vld   <= 1'b0;
            r_pend_edge <= 1'b0;
            r_slot      <= '0;
        end else begin
            r_out_vld <= 1'b0;
            case (r_state)
                ST_IDLE: begin
                    if (i_start && !i_in.req_type) begin
                        r_idle <= w_idle_inc;
                        if ({1'b0, w_idle_inc} > 18'(r_idle_limit) && !r_done_bit) begin
                            r_done_bit <= 1'b1;
                            r_out_vld  <= 1'b1;
                            r_out <= '{result_kind: KIND_DONE, queue_index: 5'd0,
                                       out_vertex: 32'd0, new_dist: 32'd0, slot: 3'd0,
                                       last_in_batch: 1'b0, done_value: 1'b1};
                        end
                    end else if (i_start) begin
                        r_idle <= '0;
                        r_vtx  <= i_in.dest_vertex;
                        r_dist <= i_in.source_dist + i_in.edge_weight;
                        if (r_done_bit) begin
                            r_done_bit <= 1'b0;
                            r_out_vld  <= 1'b1;
                            r_out <= '{result_kind: KIND_DONE, queue_index: 5'd0,
                                       out_vertex: 32'd0, new_dist: 32'd0, slot: 3'd0,
                                       last_in_batch: 1'b0, done_value: 1'b0};
                        end
                    end
                end
                ST_DIV: begin
                    if (div_done) begin
                        r_q <= div_quot[QW-1:0];
                        // out of range: drop and flag
                        r_pend_edge <= (div_quot >= 32'(w_limit));
                        if (div_quot >= 32'(w_limit)) begin
                            r_out_vld <= 1'b1;
                            r_out <= '{result_kind: KIND_DROP, queue_index: 5'd0,
                                       out_vertex: r_vtx, new_dist: r_dist, slot: 3'd0,
                                       last_in_batch: 1'b0, done_value: r_done_bit};
                        end
                    end
                end
                ST_WRITE: r_slot <= '0;
                ST_EMIT: begin
                    r_slot    <= r_slot + 1'b1;
                    r_out_vld <= 1'b1;
                    r_out <= '{result_kind: KIND_BATCH, queue_index: 5'(r_q),
                               out_vertex: r_st_rdata[63:32], new_dist: r_st_rdata[31:0],
                               slot: 3'(r_slot),
                               last_in_batch: (r_slot == SW'(BATCH_LEN - 1)),
                               done_value: r_done_bit};
                end
                default: ;
            endcase
        end
    end

    assign o_valid = r_out_vld;
    assign o_out   = r_out;

`ifndef SYNTHESIS
    a_emit_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT) |=> r_out_vld) else $error("batch element lost");
    a_write_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WRITE) |=> (r_slot == '0)) else $error("slot not reset");
    a_emit_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT && r_slot == SW'(BATCH_LEN - 1)) |=> r_state == ST_IDLE)
        else $error("batch overran");
    a_idle_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(r_idle) == IDLE_MAX && r_idle != '0) |-> r_idle == IDLE_MAX)
        else $error("idle count wrapped");
`endif
endmodule

### hdl/gub_divider.sv
`timescale 1ns / 1ps
module gub_divider import gub_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_dividend,
    input  logic [31:0] i_divisor,
    output logic        o_done,
    output logic [31:0] o_quot
);
    // restoring division, one quotient bit per cycle
    logic [31:0] r_rem, n_rem;
    logic [31:0] r_quot, n_quot;
    logic [31:0] r_div;
    logic [5:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [32:0] w_trial;
    logic [32:0] w_shift;

    always_comb begin
        w_shift = {r_rem, r_quot[31]};
        w_trial = w_shift - {1'b0, r_div};
        n_quot  = {r_quot[30:0], ~w_trial[32]};
        n_rem   = w_trial[32] ? w_shift[31:0] : w_trial[31:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'd0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= '0;
            r_quot <= i_dividend;
            r_div  <= i_divisor;
        end else if (r_busy) begin
            r_rem  <= n_rem;
            r_quot <= n_quot;
        end
    end

    assign o_done = r_done;
    assign o_quot = (r_div == 32'd0) ? 32'hFFFF_FFFF : r_quot;

`ifndef SYNTHESIS
    a_done_ends_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy) else $error("divider done while busy");
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |=> r_busy) else $error("divider did not start");
    a_count_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && r_cnt == 6'd31 && !i_start) |=> r_done)
        else $error("divider missed done");
`endif
endmodule

### sim/tb_graph_update_batcher_top.sv
`timescale 1ns / 1ps
// Self-checking bench for the graph update batcher. A scoreboard class keeps
// its own copy of the fill indexes, batch slots, idle counter and done flag.
// Every accepted item is run through it, and the results it predicts wait in
// a queue. Each strobed result is checked against the oldest one waiting.

import gub_pkg::*;

class update_scoreboard;
    // Number of queues and slots in the block as instantiated.
    localparam int NQ = 32;
    localparam int NS = 8;
    localparam int unsigned IDLE_SAT = 131071;

    logic [31:0] part_size;
    logic [5:0]  queues_cfg;
    logic [15:0] idle_lim;

    logic [31:0] slot_vtx [NQ*NS];
    logic [31:0] slot_dist[NQ*NS];
    int unsigned fill     [NQ];
    int unsigned idle_cnt;
    logic        done_flag;

    t_out_item   pending_q[$];
    int unsigned errors, n_items, n_results, n_batches, n_drops, n_status;

    function new();
        part_size  = PART_SIZE_RST;
        queues_cfg = QUEUES_RST;
        idle_lim   = IDLE_LIMIT_RST;
        foreach (fill[i]) fill[i] = 0;
        idle_cnt  = 0;
        done_flag = 1'b0;
        errors = 0; n_items = 0; n_results = 0;
        n_batches = 0; n_drops = 0; n_status = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        case (idx)
            REG_PART_SIZE:  part_size  = data;
            REG_QUEUES:     queues_cfg = data[5:0];
            REG_IDLE_LIMIT: idle_lim   = data[15:0];
            default: ;
        endcase
    endfunction

    function void push(logic [1:0] kind, logic [4:0] q, logic [31:0] v,
                       logic [31:0] d, logic [2:0] s, logic l);
        t_out_item r;
        r.result_kind   = kind;
        r.queue_index   = q;
        r.out_vertex    = v;
        r.new_dist      = d;
        r.slot          = s;
        r.last_in_batch = l;
        r.done_value    = done_flag;
        pending_q.push_back(r);
    endfunction

    // Predict the results of one accepted item.
    function void note_item(t_in_item it);
        logic [31:0] sum, quo;
        int unsigned lim, q, f;
        n_items++;
        if (!it.req_type) begin
            if (idle_cnt < IDLE_SAT) idle_cnt++;
            if (idle_cnt > idle_lim && !done_flag) begin
                done_flag = 1'b1;
                push(KIND_DONE, '0, '0, '0, '0, 1'b0);
            end
            return;
        end
        idle_cnt = 0;
        if (done_flag) begin
            done_flag = 1'b0;
            push(KIND_DONE, '0, '0, '0, '0, 1'b0);
        end
        sum = it.source_dist + it.edge_weight;
        quo = (part_size == 0) ? 32'hFFFF_FFFF : it.dest_vertex / part_size;
        lim = (queues_cfg > NQ) ? NQ : queues_cfg;
        if (quo >= lim) begin
            push(KIND_DROP, '0, it.dest_vertex, sum, '0, 1'b0);
            return;
        end
        q = quo;
        f = (fill[q] >= NS) ? 0 : fill[q];
        slot_vtx[q*NS+f]  = it.dest_vertex;
        slot_dist[q*NS+f] = sum;
        if (f == NS-1) begin
            fill[q] = 0;
            for (int s = 0; s < NS; s++)
                push(KIND_BATCH, q[4:0], slot_vtx[q*NS+s], slot_dist[q*NS+s],
                     s[2:0], s == NS-1);
        end else begin
            fill[q] = f + 1;
        end
    endfunction

    function void check_result(t_out_item got);
        t_out_item want;
        n_results++;
        if (pending_q.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected result %p", got);
            return;
        end
        want = pending_q.pop_front();
        case (want.result_kind)
            KIND_BATCH: if (want.last_in_batch) n_batches++;
            KIND_DROP:  n_drops++;
            default:    n_status++;
        endcase
        if (got.result_kind != want.result_kind || got.queue_index != want.queue_index ||
            got.out_vertex != want.out_vertex || got.new_dist != want.new_dist ||
            got.slot != want.slot || got.last_in_batch != want.last_in_batch ||
            got.done_value != want.done_value) begin
            errors++;
            if (errors <= 10)
                $display("mismatch: expected %p, got %p", want, got);
        end
    endfunction
endclass

module tb_graph_update_batcher_top;
    // Index with no register behind it; writes there must be ignored.
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
    localparam logic REQ_POLL = 1'b0;
    localparam logic REQ_EDGE = 1'b1;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_start = 1'b0;
    t_in_item             i_in = '0;
    logic                 o_busy;
    logic                 o_valid;
    t_out_item            o_out;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [CFG_W-1:0]     i_cfg_data = '0;

    update_scoreboard sb = new();
    bit calm;   // suppress random gaps on the input side

    graph_update_batcher_top u_top (.*);

    always #1 i_clk = ~i_clk;

    // Results cannot be held off: take each one on the edge that ends its strobe.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) sb.check_result(o_out);
    end

    // Present one item, hold it until the block takes it, then maybe pause.
    task automatic send(t_in_item it);
        i_start <= 1'b1;
        i_in    <= it;
        do @(posedge i_clk); while (o_busy);
        sb.note_item(it);
        if (!calm && $urandom_range(0, 99) < 14) begin
            i_start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    endtask

    task automatic edge_item(logic [31:0] d, logic [31:0] w, logic [31:0] v);
        t_in_item it;
        it.req_type    = REQ_EDGE;
        it.source_dist = d;
        it.edge_weight = w;
        it.dest_vertex = v;
        send(it);
    endtask

    task automatic poll_item();
        t_in_item it;
        it.req_type    = REQ_POLL;
        it.source_dist = $urandom;
        it.edge_weight = $urandom;
        it.dest_vertex = $urandom;
        send(it);
    endtask

    // Drop start, let every predicted result arrive, then allow for the
    // longest edge that produces nothing.
    task automatic drain();
        int unsigned guard;
        i_start <= 1'b0;
        guard = 0;
        while (sb.pending_q.size() != 0 && guard < 5000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (60) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        sb.write_reg(idx, data);
    endtask

    // One random phase: mostly edges aimed at live queues, some polls, some
    // destinations anywhere in the 32-bit range.
    task automatic random_phase(int unsigned n);
        int unsigned lim, span, pick;
        lim  = (sb.queues_cfg > 32) ? 32 : sb.queues_cfg;
        span = sb.part_size * lim;
        for (int unsigned k = 0; k < n; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < 18)
                poll_item();
            else if (pick < 88 && span != 0)
                edge_item($urandom, $urandom, $urandom_range(0, span - 1));
            else
                edge_item($urandom, $urandom, $urandom);
        end
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: wrap of the distance sum, queue 0 filling to a full
        // batch, destinations just past the live queues and at the top.
        calm = 1'b1;
        edge_item(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0);
        edge_item(32'd0, 32'd0, 32'd126);
        edge_item(32'd5, 32'd7, 32'd254);
        edge_item(32'd1, 32'd2, 32'hFFFF_FFFF);
        for (int i = 0; i < 6; i++) edge_item($urandom, $urandom, i * 20);
        drain();

        // Zero divisor drops everything; zero idle limit raises done on the
        // first poll, a second poll stays silent, an edge clears it first.
        write_reg(REG_PART_SIZE, 32'd0);
        write_reg(REG_IDLE_LIMIT, 32'hFFFF_0000);
        write_reg(REG_UNUSED, 32'hDEAD_BEEF);
        poll_item();
        poll_item();
        edge_item(32'd3, 32'd4, 32'd0);
        drain();

        // No live queues: every update drops.
        write_reg(REG_PART_SIZE, 32'd1);
        write_reg(REG_QUEUES, 32'hFFFF_FFC0);
        edge_item(32'd9, 32'd9, 32'd0);
        drain();

        // Largest divisor, queue count clamped from 63, top vertex.
        write_reg(REG_PART_SIZE, 32'hFFFF_FFFF);
        write_reg(REG_QUEUES, 32'd63);
        for (int i = 0; i < 7; i++) edge_item($urandom, $urandom, $urandom);
        edge_item(32'd1, 32'd1, 32'hFFFF_FFFF);
        drain();

        // Small idle limit: done rises once past the limit, then stays silent.
        write_reg(REG_IDLE_LIMIT, 32'd5);
        for (int i = 0; i < 9; i++) poll_item();
        edge_item(32'd0, 32'd0, 32'd0);
        drain();
        calm = 1'b0;

        // Random phases across several settings.
        write_reg(REG_PART_SIZE, 32'd4);
        write_reg(REG_QUEUES, 32'd2);
        write_reg(REG_IDLE_LIMIT, 32'd2);
        random_phase(62);
        drain();

        write_reg(REG_PART_SIZE, 32'd1);
        write_reg(REG_QUEUES, 32'd32);
        write_reg(REG_IDLE_LIMIT, 32'd0);
        random_phase(62);
        drain();

        // Long stretch without input gaps.
        calm = 1'b1;
        write_reg(REG_PART_SIZE, $urandom_range(2, 9));
        write_reg(REG_QUEUES, 32'd1);
        write_reg(REG_IDLE_LIMIT, 32'd4);
        random_phase(62);
        drain();
        calm = 1'b0;

        write_reg(REG_PART_SIZE, $urandom_range(1, 1000));
        write_reg(REG_QUEUES, $urandom_range(1, 63));
        write_reg(REG_IDLE_LIMIT, $urandom_range(0, 3));
        random_phase(62);
        drain();

        $display("items %0d, results %0d: %0d full batches, %0d drops, %0d done changes",
                 sb.n_items, sb.n_results, sb.n_batches, sb.n_drops, sb.n_status);
        $display("covered zero/max divisor, clamped and zero queue counts, done set/clear");
        if (sb.errors == 0 && sb.pending_q.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("errors %0d, still waiting %0d", sb.errors, sb.pending_q.size());
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin
        #3_000_000;
        $display("TEST FAILED");
        $finish;
    end
endmodule

### sim.f
hdl/gub_pkg.sv
hdl/gub_divider.sv
hdl/graph_update_batcher_top.sv
sim/tb_graph_update_batcher_top.sv
